// ----- src/afrp_pkg.sv -----
package afrp_pkg;

  // widths fixed by the register map and the word format
  localparam int RATE_W    = 18;
  localparam int SPAN_W    = 30;
  localparam int LEAD_W    = 15;
  localparam int RING_W    = 24;
  localparam int TIME_W    = 64;
  localparam int POS_W     = 32;
  localparam int REM_W     = 30;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 2;

  // dt * rate + remainder stays below 2^49, so the quotient by 1e9 fits 20 bits
  localparam int ACC_W  = 49;
  localparam int Q_W    = 20;

  localparam logic [ACC_W-1:0] NS_PER_SEC = ACC_W'(64'd1000000000);

  // quotient estimate: (acc >> 18) * floor(2^50 / 1e9) >> 32, at most one short of the
  // true quotient
  localparam int              RECIP_SH    = 18;
  localparam int              RECIP_Q_LSB = 32;
  localparam logic [20:0]     RECIP_M     = 21'd1125899;

  // shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 30;
  localparam int MUL_P_W = 62;

  localparam int MAX_CHUNKS = 64;
  localparam int CNT_W      = $clog2(MAX_CHUNKS);

  localparam int CHUNK_FRAMES_DEF = 512;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(48000);
  localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(20000000);
  localparam logic [LEAD_W-1:0] LEAD_RST = LEAD_W'(24000);
  localparam logic [RING_W-1:0] RING_RST = RING_W'(16384);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_PREPARE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_CATCHUP     = 2'd1,
    REG_LEAD_LIMIT  = 2'd2,
    REG_RING_FRAMES = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RECIP,
    S_BACK,
    S_DIV,
    S_CLAMP,
    S_EMIT
  } state_t;

endpackage

// ----- src/audio_frame_release_pacer.sv -----
// start, stop, prepare and stopped ticks go straight to the emit state and load their single word there
// running tick: rate multiply, reciprocal estimate of the quotient by 1e9, back-multiply,
//   compare-subtract fix-up of the estimate, clamp, then the first word is loaded, then
//   one chunk word per cycle while out_ready holds
// throughput: one event at a time; next event taken once the last word is in the output register
// reset: synchronous active-low rst_n clears pacing state and loads register defaults
module audio_frame_release_pacer
  import afrp_pkg::*;
#(
  parameter int CHUNK_FRAMES = CHUNK_FRAMES_DEF,
  localparam int LEN_W = $clog2(CHUNK_FRAMES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [TIME_W-1:0] in_now_ns,
  input  logic [POS_W-1:0]  in_app_pos,
  input  logic              in_is_draining,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [RING_W-1:0] out_chunk_offset,
  output logic [LEN_W-1:0]  out_chunk_len,
  output logic [POS_W-1:0]  out_play_pos,
  output logic              out_underrun,
  output logic              out_last
);

  state_t state_r, state_nxt;

  logic [RATE_W-1:0] rate_r;
  logic [SPAN_W-1:0] span_r;
  logic [LEAD_W-1:0] lead_r;
  logic [RING_W-1:0] ring_r;

  logic [TIME_W-1:0] last_time_r;
  logic [REM_W-1:0]  remainder_r;
  logic [POS_W-1:0]  play_count_r;
  logic [RING_W-1:0] ring_off_r;
  logic              underrun_r;
  logic              running_r;

  logic [SPAN_W-1:0] dt_r;
  logic [POS_W-1:0]  app_r;
  logic              drain_r;
  logic [ACC_W-1:0]  acc_r;
  logic [Q_W-1:0]    q_r;
  logic [LEAD_W-1:0] want_r;
  logic [CNT_W-1:0]  n_r;

  logic              out_valid_r;
  logic [RING_W-1:0] out_off_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_und_r;
  logic              out_last_r;

  logic in_fire, load_ok;

  // elapsed time with backwards steps and the catch-up span folded in
  logic [TIME_W-1:0] diff;
  logic [SPAN_W-1:0] dt_sel;

  // shared multiplier: rate product, quotient estimate and back-multiply by 1e9
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // shared compare-subtract step
  logic              div_ge;
  logic [ACC_W-1:0]  div_sub;

  // clamp of the due count
  logic [LEAD_W-1:0] want_clamp;
  logic [POS_W-1:0]  avail;
  logic              short;

  // chunk cutting
  logic [RING_W-1:0] ring_eff, off_eff, space;
  logic [LEN_W-1:0]  chunk0, chunk;
  logic              wraps;
  logic [LEAD_W-1:0] want_left;
  logic              chunk_last;

  assign in_fire  = in_valid && in_ready;
  assign load_ok  = !out_valid_r || out_ready;

  assign diff   = in_now_ns - last_time_r;
  assign dt_sel = (in_now_ns <= last_time_r) ? '0 :
                  (diff > TIME_W'(span_r))   ? span_r : diff[SPAN_W-1:0];

  always_comb begin
    mul_a = MUL_A_W'(dt_r);
    mul_b = MUL_B_W'(rate_r);
    unique case (state_r)
      S_RECIP: begin
        mul_a = MUL_A_W'(acc_r[ACC_W-1:RECIP_SH]);
        mul_b = MUL_B_W'(RECIP_M);
      end
      S_BACK: begin
        mul_a = MUL_A_W'(q_r);
        mul_b = MUL_B_W'(NS_PER_SEC);
      end
      default: ;
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  assign div_ge  = (acc_r >= NS_PER_SEC);
  assign div_sub = acc_r - NS_PER_SEC;

  assign want_clamp = (q_r > Q_W'(lead_r)) ? lead_r : LEAD_W'(q_r);
  assign avail      = app_r - play_count_r;
  assign short      = (q_r != '0) && (avail < POS_W'(want_clamp));

  assign ring_eff  = (ring_r == '0) ? RING_W'(1) : ring_r;
  assign off_eff   = (ring_off_r >= ring_eff) ? '0 : ring_off_r;
  assign space     = ring_eff - off_eff;
  assign chunk0    = (want_r > LEAD_W'(CHUNK_FRAMES)) ? LEN_W'(CHUNK_FRAMES) : LEN_W'(want_r);
  assign wraps     = (RING_W'(chunk0) >= space);
  assign chunk     = wraps ? LEN_W'(space) : chunk0;
  assign want_left = want_r - LEAD_W'(chunk);
  assign chunk_last = (want_left == '0) || (n_r == CNT_W'(MAX_CHUNKS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_op) == OP_TICK && running_r) state_nxt = S_MUL;
          else state_nxt = S_EMIT;
        end
      end
      S_MUL:   state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_BACK;
      S_BACK:  state_nxt = S_DIV;
      S_DIV:   if (!div_ge) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_EMIT;
      S_EMIT: begin
        if (load_ok && (want_r == '0 || chunk_last)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_offset = out_off_r;
  assign out_chunk_len    = out_len_r;
  assign out_play_pos     = out_pos_r;
  assign out_underrun     = out_und_r;
  assign out_last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST;
      span_r <= SPAN_RST;
      lead_r <= LEAD_RST;
      ring_r <= RING_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_RATE: rate_r <= cfg_data[RATE_W-1:0];
        REG_CATCHUP:     span_r <= cfg_data[SPAN_W-1:0];
        REG_LEAD_LIMIT:  lead_r <= cfg_data[LEAD_W-1:0];
        REG_RING_FRAMES: ring_r <= cfg_data[RING_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r  <= '0;
      remainder_r  <= '0;
      play_count_r <= '0;
      ring_off_r   <= '0;
      underrun_r   <= 1'b0;
      running_r    <= 1'b0;
      want_r       <= '0;
      n_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // in the emit state the output register is only touched by the load below
      if (out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            want_r <= '0;
            n_r    <= '0;
            unique case (op_t'(in_op))
              OP_START: begin
                last_time_r <= in_now_ns;
                remainder_r <= '0;
                running_r   <= 1'b1;
              end
              OP_STOP: running_r <= 1'b0;
              OP_PREPARE: begin
                play_count_r <= '0;
                ring_off_r   <= '0;
                remainder_r  <= '0;
                underrun_r   <= 1'b0;
                running_r    <= 1'b0;
                last_time_r  <= in_now_ns;
              end
              OP_TICK: begin
                last_time_r <= in_now_ns;
                dt_r        <= dt_sel;
                app_r       <= in_app_pos;
                drain_r     <= in_is_draining;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          acc_r <= mul_p[ACC_W-1:0] + ACC_W'(remainder_r);
        end
        S_RECIP: begin
          q_r <= mul_p[RECIP_Q_LSB +: Q_W];
        end
        S_BACK: begin
          acc_r <= acc_r - mul_p[ACC_W-1:0];
        end
        S_DIV: begin
          // estimate can be one short, fix it up against 1e9
          if (div_ge) begin
            acc_r <= div_sub;
            q_r   <= q_r + Q_W'(1);
          end
        end
        S_CLAMP: begin
          remainder_r <= acc_r[REM_W-1:0];
          if (q_r == '0) begin
            want_r <= '0;
          end else if (short) begin
            want_r <= avail[LEAD_W-1:0];
            if (!drain_r) underrun_r <= 1'b1;
          end else begin
            want_r <= want_clamp;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            out_valid_r <= 1'b1;
            out_und_r   <= underrun_r;
            if (want_r == '0) begin
              out_off_r  <= ring_off_r;
              out_len_r  <= '0;
              out_pos_r  <= play_count_r;
              out_last_r <= 1'b1;
            end else begin
              out_off_r    <= off_eff;
              out_len_r    <= chunk;
              out_pos_r    <= play_count_r + POS_W'(chunk);
              out_last_r   <= chunk_last;
              play_count_r <= play_count_r + POS_W'(chunk);
              ring_off_r   <= wraps ? '0 : off_eff + RING_W'(chunk);
              want_r       <= want_left;
              n_r          <= n_r + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // an empty word always closes its event
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_len == '0 |-> out_last)
    else $error("zero-length word without last");

  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chunk_len <= LEN_W'(CHUNK_FRAMES))
    else $error("chunk longer than packet size");

  // release position follows every chunk that is loaded
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && load_ok && want_r != '0
      |=> out_play_pos == play_count_r && out_chunk_len != '0)
    else $error("release position out of step with chunk");

  // the divider never leaves a remainder of 1e9 or more
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLAMP |-> acc_r < NS_PER_SEC)
    else $error("divide remainder out of range");

endmodule
